### design/scc_pkg.sv
// Shared constants and field widths for the sliding cross covariance block.
package scc_pkg;

	// Window storage depth and derived address widths.
	localparam int MAX_WINDOW = 1024;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

	// Field widths fixed by the item formats.
	localparam int KIND_W    = 2;
	localparam int INDEX_W   = 10;
	localparam int SAMPLE_W  = 24;
	localparam int CFG_W     = 11;
	localparam int COV_W     = 59;
	localparam int WIN_IDX_W = 32;

	// Datapath widths: a sample minus a mean, and that difference times a coefficient.
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + SAMPLE_W;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

	// Window length after reset.
	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(MAX_WINDOW);

endpackage

### design/scc_intf.sv
// Handshake channel interfaces for input items, results and the setup register.

interface scc_in_if;
	logic                               valid;
	logic                               ready;
	logic [scc_pkg::KIND_W-1:0]         kind;
	logic [scc_pkg::INDEX_W-1:0]        index;
	logic signed [scc_pkg::SAMPLE_W-1:0] value;
	logic signed [scc_pkg::SAMPLE_W-1:0] mean;

	modport source (output valid, kind, index, value, mean, input ready);
	modport sink   (input valid, kind, index, value, mean, output ready);
endinterface

interface scc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [scc_pkg::COV_W-1:0]    covariance;
	logic [scc_pkg::WIN_IDX_W-1:0]       window_index;

	modport source (output valid, covariance, window_index, input ready);
	modport sink   (input valid, covariance, window_index, output ready);
endinterface

interface scc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [scc_pkg::CFG_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### design/scc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module scc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data read appears in the cycle after the read enable.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/sliding_cross_covariance.sv
// Top level: streamed cross covariance of a stored query against each series window.
// A sample that completes a window starts a run of the single multiply-accumulate that
// walks the sample ring over the effective window length L; no new item or setup beat is
// taken until the result of that window has been loaded into the output register. Query
// loads, restarts and samples that do not yet complete a window leave the block idle. Reset
// clears the ring pointer, fill count, window counter and sets the length to 1024; the query
// store and rings are not cleared.
module sliding_cross_covariance (
	input logic          clk,
	input logic          arst_n,
	scc_in_if.sink       items,
	scc_out_if.source    results,
	scc_cfg_if.sink      setup
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_PUSH
	} state_t;

	state_t state_q;

	logic [scc_pkg::CFG_W-1:0]     wlen_q;
	logic [scc_pkg::PTR_W-1:0]     wptr_q;
	logic [scc_pkg::LEN_W-1:0]     held_q;
	logic [scc_pkg::WIN_IDX_W-1:0] win_cnt_q;
	logic [scc_pkg::WIN_IDX_W-1:0] run_idx_q;
	logic [scc_pkg::LEN_W-1:0]     k_q;
	logic [scc_pkg::PTR_W-1:0]     ring_addr_q;

	logic [scc_pkg::LEN_W-1:0]     len_eff;
	logic [scc_pkg::LEN_W-1:0]     len_m1;
	logic [scc_pkg::LEN_W-1:0]     held_inc;
	logic                          in_fire;
	logic                          cfg_fire;
	logic                          is_sample;

	logic [2*scc_pkg::SAMPLE_W-1:0] ring_rdata;
	logic [scc_pkg::SAMPLE_W-1:0]   query_rdata;
	logic                           ring_re;

	// Pipeline of the multiply-accumulate.
	logic                                 v_s1, first_s1, last_s1;
	logic                                 v_s2, last_s2;
	logic                                 v_s3, last_s3;
	logic signed [scc_pkg::DIFF_W-1:0]    diff_s2;
	logic signed [scc_pkg::SAMPLE_W-1:0]  q_s2;
	logic signed [scc_pkg::PROD_W-1:0]    prod_s3;
	logic signed [scc_pkg::SAMPLE_W-1:0]  mean_q;
	logic signed [scc_pkg::COV_W-1:0]     acc_q;

	logic signed [scc_pkg::SAMPLE_W-1:0]  rd_sample;
	logic signed [scc_pkg::SAMPLE_W-1:0]  rd_mean;
	logic signed [scc_pkg::SAMPLE_W-1:0]  mean_sel;

	logic                                 out_valid_q;
	logic signed [scc_pkg::COV_W-1:0]     out_cov_q;
	logic [scc_pkg::WIN_IDX_W-1:0]        out_idx_q;

	// Handshakes. Both channels are taken only while idle, and a setup beat goes first.
	assign items.ready = (state_q == ST_IDLE) && !setup.valid;
	assign setup.ready = (state_q == ST_IDLE);
	assign in_fire     = items.valid & items.ready;
	assign cfg_fire    = setup.valid & setup.ready;
	assign is_sample   = in_fire && (items.kind == scc_pkg::KIND_SAMPLE);

	// Effective window length: zero counts as one, large values saturate.
	always_comb begin
		if (wlen_q == '0) begin
			len_eff = scc_pkg::LEN_W'(1);
		end else if (scc_pkg::LEN_W'(wlen_q) > scc_pkg::LEN_W'(scc_pkg::MAX_WINDOW)) begin
			len_eff = scc_pkg::LEN_W'(scc_pkg::MAX_WINDOW);
		end else begin
			len_eff = scc_pkg::LEN_W'(wlen_q);
		end
	end

	assign len_m1   = len_eff - scc_pkg::LEN_W'(1);
	assign held_inc = (held_q < scc_pkg::LEN_W'(scc_pkg::MAX_WINDOW)) ?
		held_q + scc_pkg::LEN_W'(1) : held_q;

	// Sample and mean share one ring entry, so the window start yields both at once.
	assign ring_re = (state_q == ST_RUN);

	scc_ram #(
		.WIDTH (2 * scc_pkg::SAMPLE_W),
		.DEPTH (scc_pkg::MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (is_sample),
		.waddr (wptr_q),
		.wdata ({items.value, items.mean}),
		.re    (ring_re),
		.raddr (ring_addr_q),
		.rdata (ring_rdata)
	);

	scc_ram #(
		.WIDTH (scc_pkg::SAMPLE_W),
		.DEPTH (scc_pkg::MAX_WINDOW)
	) u_query (
		.clk   (clk),
		.we    (in_fire && (items.kind == scc_pkg::KIND_LOAD)),
		.waddr (items.index[scc_pkg::PTR_W-1:0]),
		.wdata (items.value),
		.re    (ring_re),
		.raddr (k_q[scc_pkg::PTR_W-1:0]),
		.rdata (query_rdata)
	);

	// The first ring read of a window carries the window-start mean.
	assign rd_sample = $signed(ring_rdata[2*scc_pkg::SAMPLE_W-1:scc_pkg::SAMPLE_W]);
	assign rd_mean   = $signed(ring_rdata[scc_pkg::SAMPLE_W-1:0]);
	assign mean_sel  = first_s1 ? rd_mean : mean_q;

	// Sequencer, series state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= scc_pkg::LEN_RESET;
			wptr_q      <= '0;
			held_q      <= '0;
			win_cnt_q   <= '0;
			run_idx_q   <= '0;
			k_q         <= '0;
			ring_addr_q <= '0;
			out_valid_q <= 1'b0;
			out_cov_q   <= '0;
			out_idx_q   <= '0;
		end else begin
			// A taken result empties the output register unless a new one is loaded.
			if (results.valid && results.ready && (state_q != ST_PUSH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						wlen_q    <= setup.data;
						wptr_q    <= '0;
						held_q    <= '0;
						win_cnt_q <= '0;
					end else if (in_fire && (items.kind == scc_pkg::KIND_RESTART)) begin
						wptr_q    <= '0;
						held_q    <= '0;
						win_cnt_q <= '0;
					end else if (is_sample) begin
						wptr_q <= wptr_q + scc_pkg::PTR_W'(1);
						held_q <= held_inc;
						if (held_inc >= len_eff) begin
							ring_addr_q <= wptr_q - len_m1[scc_pkg::PTR_W-1:0];
							k_q         <= '0;
							run_idx_q   <= win_cnt_q;
							win_cnt_q   <= win_cnt_q + scc_pkg::WIN_IDX_W'(1);
							state_q     <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					k_q         <= k_q + scc_pkg::LEN_W'(1);
					ring_addr_q <= ring_addr_q + scc_pkg::PTR_W'(1);
					if (k_q == len_m1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						out_cov_q   <= acc_q;
						out_idx_q   <= run_idx_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Valid flags of the multiply-accumulate pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ring_re;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Pipeline payload: difference, product, then accumulation.
	always_ff @(posedge clk) begin
		first_s1 <= ring_re && (k_q == '0);
		last_s1  <= ring_re && (k_q == len_m1);
		if (v_s1 && first_s1) begin
			mean_q <= rd_mean;
		end
		diff_s2 <= scc_pkg::DIFF_W'(rd_sample) - scc_pkg::DIFF_W'(mean_sel);
		q_s2    <= $signed(query_rdata);
		last_s2 <= v_s1 && last_s1;
		prod_s3 <= diff_s2 * q_s2;
		last_s3 <= v_s2 && last_s2;
		if (state_q == ST_IDLE) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + scc_pkg::COV_W'(prod_s3);
		end
	end

	assign results.valid        = out_valid_q;
	assign results.covariance   = out_cov_q;
	assign results.window_index = out_idx_q;

endmodule
